// File: hw/rtl/length_prefixed_packet_ring_core_defines.svh
// Assertion macros shared by the packet ring RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LENGTH_PREFIXED_PACKET_RING_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_RING_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define LPPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LPPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lppr_pkg.sv
// Types and codes for the length-prefixed packet ring.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package lppr_pkg;

  localparam int PLEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 7;

  // Request opcodes
  localparam logic [1:0] OP_HDR  = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ACCEPT    = 3'd0;
  localparam logic [2:0] ST_REJECT    = 3'd1;
  localparam logic [2:0] ST_BYTE      = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_EMPTY_PKT = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [PLEN_W-1:0] packet_length;
    logic [BYTE_W-1:0] data_byte;
    logic              sink_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [FREE_W-1:0] free_space;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/lppr_if.sv
// Valid/ready channel interfaces for requests and results of the packet ring.
// Depends on lppr_pkg for the payload types.
`default_nettype none

interface lppr_in_if;
  logic              valid;
  logic              ready;
  lppr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lppr_out_if;
  logic               valid;
  logic               ready;
  lppr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lppr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module lppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/length_prefixed_packet_ring_core.sv
// Push header/data: result next cycle; one request per cycle unless output stalls.
// Pop: the header is read and checked in S_HDR; a packet of n bytes then streams
//   one byte per cycle while output is free (ring RAM read port, one read per byte).
// Busy, empty or unknown requests answer from idle with status ST_NONE.
// Reset clears indices, bytes-to-store count and state; ring contents stay undefined.
`default_nettype none

`include "length_prefixed_packet_ring_core_defines.svh"

module length_prefixed_packet_ring_core #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lppr_in_if.sink    in_ch,
  lppr_out_if.source out_ch
);

  localparam int IW    = $clog2(RING_DEPTH);
  localparam int CMP_W = (IW + 1 > 8) ? IW + 1 : 8;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RING_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_BYTES = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [IW-1:0]                   wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]                   ptr_r, ptr_nxt;
  logic [lppr_pkg::PLEN_W-1:0]     bts_r, bts_nxt;
  logic [lppr_pkg::PLEN_W-1:0]     cnt_r, cnt_nxt;
  logic                            pkt_acc_r, pkt_acc_nxt;
  logic [CMP_W-1:0]                free_r, free_nxt;
  logic                            out_valid_r, out_valid_nxt;
  lppr_pkg::out_item_t             out_r, out_nxt;

  logic [IW-1:0]                   used;
  logic [CMP_W-1:0]                free_now;
  logic                            in_fire;
  logic                            out_free;
  logic                            load;
  lppr_pkg::out_item_t             res;
  lppr_pkg::in_item_t              req;

  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr;
  logic [lppr_pkg::BYTE_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [IW-1:0]                   ram_raddr;
  logic [lppr_pkg::BYTE_W-1:0]     ram_rdata;

  lppr_ram #(
    .WIDTH (lppr_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Occupancy and handshake
  assign used         = wr_idx_r - rd_idx_r;
  assign free_now     = DEPTH_C - CMP_W'(used);
  assign req          = in_ch.data;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Request decode, ring access and result build
  always_comb begin
    state_nxt   = state_r;
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    ptr_nxt     = ptr_r;
    bts_nxt     = bts_r;
    cnt_nxt     = cnt_r;
    pkt_acc_nxt = pkt_acc_r;
    free_nxt    = free_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_r;
    ram_wdata   = req.data_byte;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_r;
    load        = 1'b0;
    res         = '0;
    res.last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          load            = 1'b1;
          res.status      = lppr_pkg::ST_NONE;
          res.free_space  = lppr_pkg::FREE_W'(free_now);
          unique case (req.op)
            lppr_pkg::OP_HDR: begin
              res.status = lppr_pkg::ST_REJECT;
              if (pkt_acc_r && bts_r != '0) begin
                // hold: an accepted packet is still filling
              end else if (CMP_W'(req.packet_length) + CMP_W'(1) < free_now) begin
                ram_we         = 1'b1;
                ram_wdata      = lppr_pkg::BYTE_W'(req.packet_length) + 8'd1;
                wr_idx_nxt     = wr_idx_r + IW'(1);
                bts_nxt        = req.packet_length;
                pkt_acc_nxt    = 1'b1;
                res.status     = lppr_pkg::ST_ACCEPT;
                res.free_space = lppr_pkg::FREE_W'(free_now - CMP_W'(1));
              end else begin
                bts_nxt     = req.packet_length;
                pkt_acc_nxt = 1'b0;
              end
            end
            lppr_pkg::OP_DATA: begin
              res.status = lppr_pkg::ST_REJECT;
              if (bts_r != '0) begin
                bts_nxt = bts_r - 6'd1;
                if (pkt_acc_r) begin
                  ram_we         = 1'b1;
                  wr_idx_nxt     = wr_idx_r + IW'(1);
                  res.status     = lppr_pkg::ST_ACCEPT;
                  res.free_space = lppr_pkg::FREE_W'(free_now - CMP_W'(1));
                end
              end
            end
            lppr_pkg::OP_POP: begin
              if (!req.sink_busy && used != '0) begin
                // fetch the header; the answer is decided in S_HDR
                load      = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = rd_idx_r;
                state_nxt = S_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_HDR: begin
        load      = 1'b1;
        state_nxt = S_IDLE;
        if (CMP_W'(used) < CMP_W'(ram_rdata)) begin
          // packet not complete yet
          res.status     = lppr_pkg::ST_NONE;
          res.free_space = lppr_pkg::FREE_W'(free_now);
        end else if (ram_rdata <= 8'd1) begin
          rd_idx_nxt     = rd_idx_r + IW'(1);
          res.status     = lppr_pkg::ST_EMPTY_PKT;
          res.free_space = lppr_pkg::FREE_W'(free_now + CMP_W'(1));
        end else begin
          // start streaming the packet body
          load      = 1'b0;
          free_nxt  = free_now + CMP_W'(ram_rdata);
          ptr_nxt   = rd_idx_r + IW'(1);
          cnt_nxt   = lppr_pkg::PLEN_W'(ram_rdata - 8'd1);
          ram_re    = 1'b1;
          ram_raddr = rd_idx_r + IW'(1);
          state_nxt = S_BYTES;
        end
      end

      S_BYTES: begin
        if (out_free) begin
          load           = 1'b1;
          res.status     = lppr_pkg::ST_BYTE;
          res.out_byte   = ram_rdata;
          res.last       = (cnt_r == 6'd1);
          res.free_space = lppr_pkg::FREE_W'(free_r);
          if (cnt_r == 6'd1) begin
            rd_idx_nxt = ptr_r + IW'(1);
            state_nxt  = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + IW'(1);
            cnt_nxt   = cnt_r - 6'd1;
            ram_re    = 1'b1;
            ram_raddr = ptr_r + IW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      bts_r       <= '0;
      pkt_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      bts_r       <= bts_nxt;
      pkt_acc_r   <= pkt_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and pop bookkeeping
  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    cnt_r  <= cnt_nxt;
    free_r <= free_nxt;
    out_r  <= out_nxt;
  end

  // Checks
  `LPPR_ASSERT_NOW(a_write_idle, ram_we, state_r == S_IDLE, "ring written outside idle")
  `LPPR_ASSERT_NOW(a_cnt_live, state_r == S_BYTES, cnt_r != '0, "byte stream with zero count")
  `LPPR_ASSERT_NEXT(a_stream_end, (state_r == S_BYTES) && out_free && (cnt_r == 6'd1),
                    state_r == S_IDLE, "pop did not finish after last byte")
  `LPPR_ASSERT_NOW(a_reserved, pkt_acc_r && (bts_r != '0),
                   (CMP_W'(used) + CMP_W'(bts_r)) < DEPTH_C, "open packet overruns ring")

endmodule

`default_nettype wire
